### sv/stl_pkg.sv
// Shared types, constants and keyword tables for the source text lexer.
// No dependencies; used by stl_core, stl_res_fifo and source_text_lexer_unit.
package stl_pkg;

  localparam int OFFSET_BITS   = 24;
  localparam int LENGTH_BITS   = 16;
  localparam int KEYWORD_CHARS = 7;
  localparam int KEYWORD_COUNT = 7;
  localparam int PREFIX_BITS   = 8 * KEYWORD_CHARS;
  localparam int KIND_BITS     = 5;
  localparam int VALUE_BITS    = 31;
  localparam int RES_DEPTH     = 4;
  localparam int RES_PTR_BITS  = $clog2(RES_DEPTH);
  localparam int RES_CNT_BITS  = $clog2(RES_DEPTH + 1);

  localparam logic [VALUE_BITS-1:0] INT_SAT = {VALUE_BITS{1'b1}};

  // Token kinds
  localparam logic [KIND_BITS-1:0] KIND_SEMI   = 5'd0;
  localparam logic [KIND_BITS-1:0] KIND_COMMA  = 5'd1;
  localparam logic [KIND_BITS-1:0] KIND_ADD    = 5'd2;
  localparam logic [KIND_BITS-1:0] KIND_SUB    = 5'd3;
  localparam logic [KIND_BITS-1:0] KIND_MUL    = 5'd4;
  localparam logic [KIND_BITS-1:0] KIND_DIV    = 5'd5;
  localparam logic [KIND_BITS-1:0] KIND_LT     = 5'd6;
  localparam logic [KIND_BITS-1:0] KIND_LPAREN = 5'd7;
  localparam logic [KIND_BITS-1:0] KIND_RPAREN = 5'd8;
  localparam logic [KIND_BITS-1:0] KIND_LBRACE = 5'd9;
  localparam logic [KIND_BITS-1:0] KIND_RBRACE = 5'd10;
  localparam logic [KIND_BITS-1:0] KIND_EQ     = 5'd11;
  localparam logic [KIND_BITS-1:0] KIND_EQEQ   = 5'd12;
  localparam logic [KIND_BITS-1:0] KIND_INT    = 5'd13;
  localparam logic [KIND_BITS-1:0] KIND_VARID  = 5'd14;
  localparam logic [KIND_BITS-1:0] KIND_FNID   = 5'd15;
  localparam logic [KIND_BITS-1:0] KIND_KW0    = 5'd16;
  localparam logic [KIND_BITS-1:0] KIND_EOF    = 5'd23;
  localparam logic [KIND_BITS-1:0] KIND_ERR    = 5'd24;

  // Keywords packed first character lowest, with their lengths
  localparam logic [PREFIX_BITS-1:0] KW_TEXT [KEYWORD_COUNT] = '{
    PREFIX_BITS'(64'h6E66),            // fn
    PREFIX_BITS'(64'h726176),          // var
    PREFIX_BITS'(64'h6669),            // if
    PREFIX_BITS'(64'h65736C65),        // else
    PREFIX_BITS'(64'h726F66),          // for
    PREFIX_BITS'(64'h6E7275746572),    // return
    PREFIX_BITS'(64'h6E6C746E697270)   // println
  };
  localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
    4'd2, 4'd3, 4'd2, 4'd4, 4'd3, 4'd6, 4'd7
  };

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [VALUE_BITS-1:0]  value;
    logic                   overflow;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] length;
    logic                   last;
  } result_t;

  // Up to two results produced by one byte, first in e0
  typedef struct packed {
    logic [1:0] n;
    result_t    e0;
    result_t    e1;
  } push_t;

  // Kind of a finished word
  function automatic logic [KIND_BITS-1:0] word_kind(
    input logic                   upper,
    input logic [LENGTH_BITS-1:0] len,
    input logic [PREFIX_BITS-1:0] prefix
  );
    logic [KIND_BITS-1:0] k;
    k = KIND_VARID;
    for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
      if (len == LENGTH_BITS'(KW_LEN[i]) && prefix == KW_TEXT[i]) begin
        k = KIND_KW0 + KIND_BITS'(i);
      end
    end
    if (upper) begin
      k = KIND_FNID;
    end
    return k;
  endfunction

endpackage

### sv/stl_core.sv
// Lexer state and token decision: input register, scan state, result build.
// Depends on stl_pkg; feeds stl_res_fifo through a push_t request.
module stl_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_text_byte,
  input  logic               room,
  output stl_pkg::push_t     push
);

  typedef enum logic [2:0] {M_IDLE, M_INT, M_WORD, M_EQ, M_ERR} mode_t;

  mode_t                             mode_r, mode_nxt;
  logic [stl_pkg::VALUE_BITS-1:0]    acc_r, acc_nxt;
  logic                              ovf_r, ovf_nxt;
  logic                              upper_r, upper_nxt;
  logic [stl_pkg::PREFIX_BITS-1:0]   prefix_r, prefix_nxt;
  logic [stl_pkg::LENGTH_BITS-1:0]   plen_r, plen_nxt;
  logic [stl_pkg::OFFSET_BITS-1:0]   off_r, off_nxt;
  logic [stl_pkg::OFFSET_BITS-1:0]   tstart_r, tstart_nxt;
  logic [7:0]                        byte_r;
  logic                              bvld_r;

  logic                              go;
  logic                              fall;
  logic                              a_v, b_v;
  stl_pkg::result_t                  a, b_res;
  logic [stl_pkg::LENGTH_BITS-1:0]   plen_inc;
  logic [stl_pkg::OFFSET_BITS-1:0]   off_inc;
  logic [34:0]                       acc_mac;
  logic                              is_digit, is_lower, is_upper, is_space;
  logic                              single_v;
  logic [stl_pkg::KIND_BITS-1:0]     single_k;

  function automatic stl_pkg::result_t mk_res(
    input logic [stl_pkg::KIND_BITS-1:0]   kind,
    input logic [stl_pkg::VALUE_BITS-1:0]  value,
    input logic                            ovf,
    input logic [stl_pkg::OFFSET_BITS-1:0] start,
    input logic [stl_pkg::LENGTH_BITS-1:0] len
  );
    stl_pkg::result_t r;
    r.kind     = kind;
    r.value    = value;
    r.overflow = ovf;
    r.start    = start;
    r.length   = len;
    r.last     = 1'b0;
    return r;
  endfunction

  // Byte handshake: hold a byte until the result buffer has room for two
  assign go       = bvld_r && room;
  assign in_stall = bvld_r && !room;

  // Character classes
  assign is_digit = byte_r >= 8'h30 && byte_r <= 8'h39;
  assign is_lower = byte_r >= 8'h61 && byte_r <= 8'h7A;
  assign is_upper = byte_r >= 8'h41 && byte_r <= 8'h5A;
  assign is_space = byte_r == 8'h20 || byte_r == 8'h09 || byte_r == 8'h0A || byte_r == 8'h0B;

  // Single-character tokens
  always_comb begin
    single_v = 1'b1;
    single_k = stl_pkg::KIND_SEMI;
    case (byte_r)
      8'h3B:   single_k = stl_pkg::KIND_SEMI;
      8'h2C:   single_k = stl_pkg::KIND_COMMA;
      8'h2B:   single_k = stl_pkg::KIND_ADD;
      8'h2D:   single_k = stl_pkg::KIND_SUB;
      8'h2A:   single_k = stl_pkg::KIND_MUL;
      8'h2F:   single_k = stl_pkg::KIND_DIV;
      8'h3C:   single_k = stl_pkg::KIND_LT;
      8'h28:   single_k = stl_pkg::KIND_LPAREN;
      8'h29:   single_k = stl_pkg::KIND_RPAREN;
      8'h7B:   single_k = stl_pkg::KIND_LBRACE;
      8'h7D:   single_k = stl_pkg::KIND_RBRACE;
      default: single_v = 1'b0;
    endcase
  end

  assign plen_inc = (plen_r == {stl_pkg::LENGTH_BITS{1'b1}}) ? plen_r : plen_r + 1'b1;
  assign off_inc  = off_r + 1'b1;
  // acc * 10 + digit, as shifts and adds
  assign acc_mac  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {31'd0, byte_r[3:0]};

  // Next state and results for the held byte
  always_comb begin
    mode_nxt   = mode_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    upper_nxt  = upper_r;
    prefix_nxt = prefix_r;
    plen_nxt   = plen_r;
    off_nxt    = off_r;
    tstart_nxt = tstart_r;
    fall       = 1'b0;
    a_v        = 1'b0;
    b_v        = 1'b0;
    a          = mk_res(stl_pkg::KIND_EOF, '0, 1'b0, off_r, '0);
    b_res      = mk_res(stl_pkg::KIND_EOF, '0, 1'b0, off_r, '0);
    if (go) begin
      // Token in progress: continue it, or close it
      case (mode_r)
        M_INT: begin
          if (is_digit) begin
            if (ovf_r || acc_mac > {4'd0, stl_pkg::INT_SAT}) begin
              acc_nxt = stl_pkg::INT_SAT;
              ovf_nxt = 1'b1;
            end else begin
              acc_nxt = acc_mac[stl_pkg::VALUE_BITS-1:0];
            end
            plen_nxt = plen_inc;
            off_nxt  = off_inc;
          end else begin
            a_v      = 1'b1;
            a        = mk_res(stl_pkg::KIND_INT, acc_r, ovf_r, tstart_r, plen_r);
            mode_nxt = M_IDLE;
            fall     = 1'b1;
          end
        end
        M_WORD: begin
          if (is_digit || is_lower || is_upper || byte_r == 8'h5F) begin
            for (int i = 0; i < stl_pkg::KEYWORD_CHARS; i++) begin
              if (plen_r == stl_pkg::LENGTH_BITS'(i)) begin
                prefix_nxt[8*i +: 8] = prefix_r[8*i +: 8] | byte_r;
              end
            end
            plen_nxt = plen_inc;
            off_nxt  = off_inc;
          end else begin
            a_v      = 1'b1;
            a        = mk_res(stl_pkg::word_kind(upper_r, plen_r, prefix_r), '0, 1'b0,
                              tstart_r, plen_r);
            mode_nxt = M_IDLE;
            fall     = 1'b1;
          end
        end
        M_EQ: begin
          mode_nxt = M_IDLE;
          a_v      = 1'b1;
          if (byte_r == 8'h3D) begin
            a       = mk_res(stl_pkg::KIND_EQEQ, '0, 1'b0, tstart_r,
                             stl_pkg::LENGTH_BITS'(2));
            off_nxt = off_inc;
          end else begin
            a    = mk_res(stl_pkg::KIND_EQ, '0, 1'b0, tstart_r,
                          stl_pkg::LENGTH_BITS'(1));
            fall = 1'b1;
          end
        end
        M_ERR: begin
          if (byte_r != 8'h00) begin
            off_nxt = off_inc;
          end else begin
            mode_nxt = M_IDLE;
            fall     = 1'b1;
          end
        end
        default: begin
          mode_nxt = M_IDLE;
          fall     = 1'b1;
        end
      endcase

      // Byte seen between tokens
      if (fall) begin
        if (byte_r == 8'h00) begin
          b_v     = 1'b1;
          b_res   = mk_res(stl_pkg::KIND_EOF, '0, 1'b0, off_r, '0);
          off_nxt = '0;
        end else begin
          if (!is_space) begin
            if (single_v) begin
              b_v   = 1'b1;
              b_res = mk_res(single_k, '0, 1'b0, off_r, stl_pkg::LENGTH_BITS'(1));
            end else begin
              tstart_nxt = off_r;
              plen_nxt   = stl_pkg::LENGTH_BITS'(1);
              if (is_digit) begin
                mode_nxt = M_INT;
                acc_nxt  = stl_pkg::VALUE_BITS'(byte_r[3:0]);
                ovf_nxt  = 1'b0;
              end else if (is_lower || is_upper) begin
                mode_nxt   = M_WORD;
                upper_nxt  = is_upper;
                prefix_nxt = stl_pkg::PREFIX_BITS'(byte_r);
              end else if (byte_r == 8'h3D) begin
                mode_nxt = M_EQ;
              end else begin
                b_v      = 1'b1;
                b_res    = mk_res(stl_pkg::KIND_ERR, '0, 1'b0, off_r,
                                  stl_pkg::LENGTH_BITS'(1));
                mode_nxt = M_ERR;
              end
            end
          end
          off_nxt = off_inc;
        end
      end
    end
  end

  // Pack the results in order, the final one marked last
  always_comb begin
    push    = '0;
    push.e0 = a;
    push.e1 = b_res;
    if (a_v && b_v) begin
      push.n       = 2'd2;
      push.e1.last = 1'b1;
    end else if (a_v) begin
      push.n       = 2'd1;
      push.e0.last = 1'b1;
    end else if (b_v) begin
      push.n       = 2'd1;
      push.e0      = b_res;
      push.e0.last = 1'b1;
    end
  end

  // Input register and lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvld_r   <= 1'b0;
      mode_r   <= M_IDLE;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
      upper_r  <= 1'b0;
      prefix_r <= '0;
      plen_r   <= '0;
      off_r    <= '0;
      tstart_r <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        bvld_r <= 1'b1;
        byte_r <= in_text_byte;
      end else if (go) begin
        bvld_r <= 1'b0;
      end
      mode_r   <= mode_nxt;
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
      upper_r  <= upper_nxt;
      prefix_r <= prefix_nxt;
      plen_r   <= plen_nxt;
      off_r    <= off_nxt;
      tstart_r <= tstart_nxt;
    end
  end

endmodule

### sv/stl_res_fifo.sv
// Result buffer: four entries; takes up to two results per cycle, gives one unless stalled.
// Depends on stl_pkg; fed by stl_core, drives the result channel.
module stl_res_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  stl_pkg::push_t   push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output stl_pkg::result_t head
);

  stl_pkg::result_t                  mem_r [stl_pkg::RES_DEPTH];
  logic [stl_pkg::RES_PTR_BITS-1:0]  wr_ptr_r, rd_ptr_r;
  logic [stl_pkg::RES_CNT_BITS-1:0]  count_r;
  logic                              pop;
  logic [stl_pkg::RES_PTR_BITS-1:0]  wr_ptr_1;

  // Room for a two-result byte
  assign room      = count_r <= stl_pkg::RES_CNT_BITS'(stl_pkg::RES_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign head      = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_1  = wr_ptr_r + 1'b1;

  // Storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.e0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_1] <= push.e1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + stl_pkg::RES_PTR_BITS'(push.n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + stl_pkg::RES_CNT_BITS'(push.n)
                 - stl_pkg::RES_CNT_BITS'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= stl_pkg::RES_CNT_BITS'(stl_pkg::RES_DEPTH))
    else $error("result buffer over-filled");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> count_r + stl_pkg::RES_CNT_BITS'(push.n)
                       <= stl_pkg::RES_CNT_BITS'(stl_pkg::RES_DEPTH))
    else $error("request pushed without room");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && push.n == 2'd0 |=> count_r == $past(count_r) - 1'b1)
    else $error("fill count wrong after pop");

endmodule

### sv/source_text_lexer_unit.sv
// Top level of the streaming source text lexer: core plus result buffer.
// Depends on stl_pkg, stl_core and stl_res_fifo.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  in_text_byte
//  out_     output     out_valid / out_stall token fields, out_is_last
//
// One byte is accepted per cycle when results are taken as they appear.
// A byte is registered on acceptance, and its results are written into the
// buffer once there is room, behind any results already waiting.
// A byte that closes a token and emits its own gives two results; the
// four-entry result buffer absorbs them, and input stalls only while the
// buffer holds more than two results.
// Reset (rst_n low, synchronous) empties the buffer and returns the lexer
// to idle with offset zero.
module source_text_lexer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_text_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [stl_pkg::KIND_BITS-1:0]      out_token_kind,
  output logic [stl_pkg::VALUE_BITS-1:0]     out_int_value,
  output logic                               out_int_overflow,
  output logic [stl_pkg::OFFSET_BITS-1:0]    out_start_offset,
  output logic [stl_pkg::LENGTH_BITS-1:0]    out_token_length,
  output logic                               out_is_last
);

  stl_pkg::push_t   push;
  stl_pkg::result_t head;
  logic             room;

  stl_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .room         (room),
    .push         (push)
  );

  stl_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Result fields
  assign out_token_kind   = head.kind;
  assign out_int_value    = head.value;
  assign out_int_overflow = head.overflow;
  assign out_start_offset = head.start;
  assign out_token_length = head.length;
  assign out_is_last      = head.last;

endmodule

### verif/stl_checker.sv
`timescale 1ns / 1ps
// Token checker for the source text lexer: predicts the tokens of every accepted
// request and compares them in order with the result channel.
// Depends on stl_pkg for the token kinds and the result layout.
module stl_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [7:0]                      in_text_byte,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [stl_pkg::KIND_BITS-1:0]   out_token_kind,
  input  logic [stl_pkg::VALUE_BITS-1:0]  out_int_value,
  input  logic                            out_int_overflow,
  input  logic [stl_pkg::OFFSET_BITS-1:0] out_start_offset,
  input  logic [stl_pkg::LENGTH_BITS-1:0] out_token_length,
  input  logic                            out_is_last,
  output int                              mismatch_count,
  output int                              tokens_outstanding
);
  import stl_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_NUMBER,
    SCAN_WORD,
    SCAN_EQUALS,
    SCAN_SKIP
  } scan_mode_e;

  localparam logic [LENGTH_BITS-1:0] LEN_SAT = '1;

  // Predicted lexer state
  scan_mode_e             scan_mode;
  logic [VALUE_BITS-1:0]  number_value;
  logic                   number_sat;
  logic                   word_upper;
  logic [7:0]             word_head [KEYWORD_CHARS];
  logic [LENGTH_BITS-1:0] token_len;
  logic [OFFSET_BITS-1:0] text_offset;
  logic [OFFSET_BITS-1:0] token_origin;

  result_t expected_tokens [$];
  result_t got_token;
  result_t want_token;
  int      errors = 0;

  function automatic bit is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_lower(input logic [7:0] b);
    return b >= "a" && b <= "z";
  endfunction

  function automatic bit is_upper(input logic [7:0] b);
    return b >= "A" && b <= "Z";
  endfunction

  function automatic bit is_word(input logic [7:0] b);
    return is_digit(b) || is_lower(b) || is_upper(b) || b == "_";
  endfunction

  // space, tab, newline, vertical tab
  function automatic bit is_blank(input logic [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0B;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] bump(input logic [LENGTH_BITS-1:0] len);
    return (len == LEN_SAT) ? len : len + 1'b1;
  endfunction

  function automatic bit single_token(input logic [7:0] b,
                                      output logic [KIND_BITS-1:0] k);
    k = KIND_SEMI;
    case (b)
      ";": k = KIND_SEMI;
      ",": k = KIND_COMMA;
      "+": k = KIND_ADD;
      "-": k = KIND_SUB;
      "*": k = KIND_MUL;
      "/": k = KIND_DIV;
      "<": k = KIND_LT;
      "(": k = KIND_LPAREN;
      ")": k = KIND_RPAREN;
      "{": k = KIND_LBRACE;
      "}": k = KIND_RBRACE;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Keyword spellings, in kind order from KIND_KW0
  function automatic string keyword_text(input int k);
    case (k)
      0: return "fn";
      1: return "var";
      2: return "if";
      3: return "else";
      4: return "for";
      5: return "return";
      default: return "println";
    endcase
  endfunction

  function automatic logic [KIND_BITS-1:0] classify_word();
    string kw;
    bit    hit;
    if (word_upper) return KIND_FNID;
    if (token_len > KEYWORD_CHARS) return KIND_VARID;
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      kw = keyword_text(k);
      if (kw.len() == int'(token_len)) begin
        hit = 1'b1;
        for (int i = 0; i < kw.len(); i++) begin
          if (kw[i] != word_head[i]) hit = 1'b0;
        end
        if (hit) return KIND_KW0 + KIND_BITS'(k);
      end
    end
    return KIND_VARID;
  endfunction

  task automatic push_token(input logic [KIND_BITS-1:0]   kind,
                            input logic [VALUE_BITS-1:0]  value,
                            input logic                   ovf,
                            input logic [OFFSET_BITS-1:0] start,
                            input logic [LENGTH_BITS-1:0] len);
    result_t t;
    t.kind     = kind;
    t.value    = value;
    t.overflow = ovf;
    t.start    = start;
    t.length   = len;
    t.last     = 1'b0;
    expected_tokens.push_back(t);
  endtask

  // Advance the predicted lexer by one request and queue its tokens
  task automatic lex_byte(input logic [7:0] b);
    int unsigned          base;
    int unsigned          digit;
    bit                   absorbed;
    logic [KIND_BITS-1:0] kind;
    base     = expected_tokens.size();
    absorbed = 1'b0;
    digit    = 0;

    // close or extend the pending token
    case (scan_mode)
      SCAN_NUMBER: begin
        if (is_digit(b)) begin
          digit = b - 8'h30;
          if (number_sat || 32'(number_value) > (32'(INT_SAT) - digit) / 10) begin
            number_value = INT_SAT;
            number_sat   = 1'b1;
          end else begin
            number_value = VALUE_BITS'(32'(number_value) * 10 + digit);
          end
          token_len = bump(token_len);
          absorbed  = 1'b1;
        end else begin
          push_token(KIND_INT, number_value, number_sat, token_origin, token_len);
          scan_mode = SCAN_IDLE;
        end
      end
      SCAN_WORD: begin
        if (is_word(b)) begin
          if (token_len < KEYWORD_CHARS) word_head[token_len] = b;
          token_len = bump(token_len);
          absorbed  = 1'b1;
        end else begin
          push_token(classify_word(), '0, 1'b0, token_origin, token_len);
          scan_mode = SCAN_IDLE;
        end
      end
      SCAN_EQUALS: begin
        scan_mode = SCAN_IDLE;
        if (b == "=") begin
          push_token(KIND_EQEQ, '0, 1'b0, token_origin, LENGTH_BITS'(2));
          absorbed = 1'b1;
        end else begin
          push_token(KIND_EQ, '0, 1'b0, token_origin, LENGTH_BITS'(1));
        end
      end
      SCAN_SKIP: begin
        if (b != 8'h00) absorbed = 1'b1;
        else scan_mode = SCAN_IDLE;
      end
      default: ;
    endcase

    // then the byte's own meaning
    if (absorbed) begin
      text_offset = text_offset + 1'b1;
    end else if (b == 8'h00) begin
      push_token(KIND_EOF, '0, 1'b0, text_offset, '0);
      text_offset = '0;
    end else begin
      if (!is_blank(b)) begin
        if (single_token(b, kind)) begin
          push_token(kind, '0, 1'b0, text_offset, LENGTH_BITS'(1));
        end else begin
          token_origin = text_offset;
          token_len    = LENGTH_BITS'(1);
          if (is_digit(b)) begin
            scan_mode    = SCAN_NUMBER;
            number_value = VALUE_BITS'(b - 8'h30);
            number_sat   = 1'b0;
          end else if (is_lower(b) || is_upper(b)) begin
            scan_mode    = SCAN_WORD;
            word_upper   = is_upper(b);
            word_head[0] = b;
          end else if (b == "=") begin
            scan_mode = SCAN_EQUALS;
          end else begin
            push_token(KIND_ERR, '0, 1'b0, text_offset, LENGTH_BITS'(1));
            scan_mode = SCAN_SKIP;
          end
        end
      end
      text_offset = text_offset + 1'b1;
    end

    if (expected_tokens.size() > base) expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endtask

  // Compare results first, then predict from the request of the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      scan_mode    = SCAN_IDLE;
      number_value = '0;
      number_sat   = 1'b0;
      word_upper   = 1'b0;
      token_len    = '0;
      text_offset  = '0;
      token_origin = '0;
      expected_tokens.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got_token.kind     = out_token_kind;
        got_token.value    = out_int_value;
        got_token.overflow = out_int_overflow;
        got_token.start    = out_start_offset;
        got_token.length   = out_token_length;
        got_token.last     = out_is_last;
        if (expected_tokens.size() == 0) begin
          errors++;
          $display("%0t: unexpected token: expected none, actual kind=%0d value=%0d ovf=%0d",
                   $realtime, got_token.kind, got_token.value, got_token.overflow,
                   " start=%0d len=%0d last=%0d",
                   got_token.start, got_token.length, got_token.last);
        end else begin
          want_token = expected_tokens.pop_front();
          if (got_token !== want_token) begin
            errors++;
            $display("%0t: token mismatch: expected kind=%0d value=%0d ovf=%0d",
                     $realtime, want_token.kind, want_token.value, want_token.overflow,
                     " start=%0d len=%0d last=%0d",
                     want_token.start, want_token.length, want_token.last);
            $display("%0t:                  actual kind=%0d value=%0d ovf=%0d",
                     $realtime, got_token.kind, got_token.value, got_token.overflow,
                     " start=%0d len=%0d last=%0d",
                     got_token.start, got_token.length, got_token.last);
          end
        end
      end
      if (in_valid && !in_stall) lex_byte(in_text_byte);
    end
    tokens_outstanding <= expected_tokens.size();
    mismatch_count     <= errors;
  end

endmodule

### verif/tb_source_text_lexer_unit.sv
`timescale 1ns / 1ps
// Testbench top for source_text_lexer_unit: clock, reset, byte stimulus, result
// channel back-pressure and the verdict. Depends on stl_pkg and stl_checker.
module tb_source_text_lexer_unit;
  import stl_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS   = 420;
  localparam int LONG_TOKEN    = 24;

  logic                   clk;
  logic                   rst_n        = 1'b0;
  logic                   in_valid     = 1'b0;
  logic                   in_stall;
  logic [7:0]             in_text_byte = 8'h00;
  logic                   out_valid;
  logic                   out_stall    = 1'b0;
  logic [KIND_BITS-1:0]   out_token_kind;
  logic [VALUE_BITS-1:0]  out_int_value;
  logic                   out_int_overflow;
  logic [OFFSET_BITS-1:0] out_start_offset;
  logic [LENGTH_BITS-1:0] out_token_length;
  logic                   out_is_last;

  int          mismatch_count;
  int          tokens_outstanding;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;

  source_text_lexer_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_kind  (out_token_kind),
    .out_int_value   (out_int_value),
    .out_int_overflow(out_int_overflow),
    .out_start_offset(out_start_offset),
    .out_token_length(out_token_length),
    .out_is_last     (out_is_last)
  );

  stl_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_text_byte      (in_text_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_token_kind    (out_token_kind),
    .out_int_value     (out_int_value),
    .out_int_overflow  (out_int_overflow),
    .out_start_offset  (out_start_offset),
    .out_token_length  (out_token_length),
    .out_is_last       (out_is_last),
    .mismatch_count    (mismatch_count),
    .tokens_outstanding(tokens_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result channel back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // One request; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input bit counted);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (counted) bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit counted);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], counted);
  endtask

  // Hold the sender until every predicted token has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (tokens_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(62);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("a" + r - 10);
    if (r < 62) return 8'("A" + r - 36);
    return "_";
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_single();
    case ($urandom_range(10))
      0:       return ";";
      1:       return ",";
      2:       return "+";
      3:       return "-";
      4:       return "*";
      5:       return "/";
      6:       return "<";
      7:       return "(";
      8:       return ")";
      9:       return "{";
      default: return "}";
    endcase
  endfunction

  // Bytes that cannot start a token
  function automatic logic [7:0] rand_invalid();
    case ($urandom_range(5))
      0:       return "_";
      1:       return 8'h0D;
      2:       return 8'h0C;
      3:       return "!";
      4:       return "#";
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(3))
      0:       return " ";
      1:       return 8'h09;
      2:       return 8'h0A;
      default: return 8'h0B;
    endcase
  endfunction

  function automatic string keyword_text(input int k);
    case (k)
      0: return "fn";
      1: return "var";
      2: return "if";
      3: return "else";
      4: return "for";
      5: return "return";
      default: return "println";
    endcase
  endfunction

  task automatic send_delimiter();
    if ($urandom_range(9) < 7) begin
      if ($urandom_range(1) == 0) send_byte(rand_blank(), 1'b1);
      else send_byte(rand_single(), 1'b1);
    end
  endtask

  // One random token, mostly well formed
  task automatic random_token();
    int    r;
    int    n;
    string kw;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 8) begin
      send_byte(rand_blank(), 1'b1);
    end else if (r < 30) begin
      send_byte(rand_single(), 1'b1);
    end else if (r < 36) begin
      send_byte("=", 1'b1);
      if ($urandom_range(1) == 0) send_byte("=", 1'b1);
    end else if (r < 52) begin
      // integers, some close to or past saturation
      case ($urandom_range(9))
        0: begin
          n = $urandom_range(11, 20);
          repeat (n) send_byte(rand_digit(), 1'b1);
        end
        1: begin
          send_text("21474836", 1'b1);
          send_byte(8'("4" + $urandom_range(1)), 1'b1);
          send_byte(rand_digit(), 1'b1);
        end
        default: begin
          n = $urandom_range(1, 9);
          repeat (n) send_byte(rand_digit(), 1'b1);
        end
      endcase
      send_delimiter();
    end else if (r < 75) begin
      if ($urandom_range(1) == 0) send_byte(8'("a" + $urandom_range(25)), 1'b1);
      else send_byte(8'("A" + $urandom_range(25)), 1'b1);
      n = $urandom_range(0, 9);
      repeat (n) send_byte(rand_word_char(), 1'b1);
      send_delimiter();
    end else if (r < 86) begin
      // keywords, exact or near misses
      kw = keyword_text($urandom_range(KEYWORD_COUNT - 1));
      case ($urandom_range(5))
        0: kw[0] = kw[0] - 8'd32;
        1: kw = {kw, "x"};
        2: kw = kw.substr(0, kw.len() - 2);
        default: ;
      endcase
      send_text(kw, 1'b1);
      send_delimiter();
    end else if (r < 92) begin
      send_byte(8'h00, 1'b1);
    end else if (r < 94) begin
      // error, ignored tail, end of text
      send_byte(rand_invalid(), 1'b1);
      n = $urandom_range(0, 6);
      repeat (n) send_byte(8'($urandom_range(1, 255)), 1'b0);
      send_byte(8'h00, 1'b1);
    end else begin
      b = 8'($urandom_range(255));
      send_byte(b, 1'b1);
      if ($urandom_range(1) == 0) send_byte(8'h00, 1'b1);
    end
  endtask

  initial begin
    // reset
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: every single-character token, both equals forms, tab, newline and
    // vertical tab, a word pending at end of text, then an error with an ignored tail
    send_text(";,+-*/<(){}=\t==", 1'b1);
    send_byte(8'h0B, 1'b1);
    send_text("\nx", 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte("_", 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b1);

    // long tokens: a function id past keyword length and an overflowing integer
    send_byte("Z", 1'b0);
    repeat (LONG_TOKEN - 1) send_byte(rand_word_char(), 1'b0);
    send_byte(";", 1'b0);
    send_byte("1", 1'b0);
    repeat (LONG_TOKEN - 1) send_byte(rand_digit(), 1'b0);
    send_byte(8'h00, 1'b0);
    settle();

    // random phases with different idling on each side
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      bytes_sent = 0;
      while (bytes_sent < PHASE_ITEMS) random_token();
      send_byte(8'h00, 1'b1);
      settle();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
